@@ rtl/ttyld_pkg.sv @@
package ttyld_pkg;

   localparam int QUEUE_DEPTH = 64;
   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam int CHAR_W = 8;
   localparam int KIND_W = 3;
   localparam int OP_W = 2;
   localparam int CSR_INDEX_W = 3;
   localparam int FLAGS_W = 5;

   // request operations
   localparam logic [OP_W-1:0] OP_RECEIVE = 2'd0;
   localparam logic [OP_W-1:0] OP_READ    = 2'd1;
   localparam logic [OP_W-1:0] OP_WRITE   = 2'd2;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_TERM_OUT  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_STORED    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_DROPPED   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_READ_DATA = 3'd3;
   localparam logic [KIND_W-1:0] KIND_READ_END  = 3'd4;
   localparam logic [KIND_W-1:0] KIND_EOF       = 3'd5;
   localparam logic [KIND_W-1:0] KIND_INTR      = 3'd6;
   localparam logic [KIND_W-1:0] KIND_EMPTY     = 3'd7;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_MODE = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_EOL  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_EOF  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_INTR = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_BELL = 3'd4;

   // mode flag bit positions
   localparam int FLAG_ECHO   = 0;
   localparam int FLAG_ECHONL = 1;
   localparam int FLAG_SIG    = 2;
   localparam int FLAG_CANON  = 3;
   localparam int FLAG_BELL   = 4;

   localparam logic [FLAGS_W-1:0] MODE_RESET = 5'd13;
   localparam logic [CHAR_W-1:0]  EOL_RESET  = 8'd10;
   localparam logic [CHAR_W-1:0]  EOF_RESET  = 8'd4;
   localparam logic [CHAR_W-1:0]  INTR_RESET = 8'd3;
   localparam logic [CHAR_W-1:0]  BELL_RESET = 8'd7;

   localparam logic [CHAR_W-1:0] CHAR_CARET = 8'h5E;
   localparam logic [CHAR_W-1:0] CHAR_QUEST = 8'h3F;
   localparam logic [CHAR_W-1:0] CHAR_DEL   = 8'h7F;
   localparam logic [CHAR_W-1:0] CHAR_CTRL  = 8'h40;
   localparam logic [CHAR_W-1:0] PRINT_LO   = 8'h20;
   localparam logic [CHAR_W-1:0] PRINT_HI   = 8'h7E;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_BELL,
      ST_DROP,
      ST_CARET,
      ST_ECHO,
      ST_STORE,
      ST_EMPTY,
      ST_READ,
      ST_WRITE
   } state_type;

   typedef enum logic [2:0] {
      RES_BELL,
      RES_DROP,
      RES_CARET,
      RES_ECHO,
      RES_STORE,
      RES_EMPTY,
      RES_READ,
      RES_WRITE
   } res_type;

   typedef struct packed {
      logic    load;
      logic    pop;
      logic    emit;
      res_type res;
   } cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            full;
      logic            empty;
      logic            bell_en;
      logic            echo_en;
      logic            caret;
      logic            out_free;
   } status_type;

endpackage

@@ rtl/ttyld_ram.sv @@
module ttyld_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/ttyld_ctrl.sv @@
module ttyld_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  ttyld_pkg::status_type status,
   output ttyld_pkg::cmd_type    cmd
);

   ttyld_pkg::state_type state_ff;
   ttyld_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ttyld_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd.load   = 1'b0;
      cmd.pop    = 1'b0;
      cmd.emit   = 1'b0;
      cmd.res    = ttyld_pkg::RES_WRITE;
      unique case (state_ff)
         ttyld_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ttyld_pkg::ST_DISPATCH;
            end
         end
         ttyld_pkg::ST_DISPATCH: begin
            case (status.op)
               ttyld_pkg::OP_RECEIVE: begin
                  if (status.full) begin
                     state_in = status.bell_en ? ttyld_pkg::ST_BELL : ttyld_pkg::ST_DROP;
                  end else if (status.echo_en) begin
                     state_in = status.caret ? ttyld_pkg::ST_CARET : ttyld_pkg::ST_ECHO;
                  end else begin
                     state_in = ttyld_pkg::ST_STORE;
                  end
               end
               ttyld_pkg::OP_READ: begin
                  if (status.empty) begin
                     state_in = ttyld_pkg::ST_EMPTY;
                  end else begin
                     cmd.pop  = 1'b1;
                     state_in = ttyld_pkg::ST_READ;
                  end
               end
               ttyld_pkg::OP_WRITE: state_in = ttyld_pkg::ST_WRITE;
               default: state_in = ttyld_pkg::ST_IDLE;
            endcase
         end
         ttyld_pkg::ST_BELL: begin
            cmd.res  = ttyld_pkg::RES_BELL;
            cmd.emit = status.out_free;
            if (status.out_free) state_in = ttyld_pkg::ST_DROP;
         end
         ttyld_pkg::ST_DROP: begin
            cmd.res  = ttyld_pkg::RES_DROP;
            cmd.emit = status.out_free;
            if (status.out_free) state_in = ttyld_pkg::ST_IDLE;
         end
         ttyld_pkg::ST_CARET: begin
            cmd.res  = ttyld_pkg::RES_CARET;
            cmd.emit = status.out_free;
            if (status.out_free) state_in = ttyld_pkg::ST_ECHO;
         end
         ttyld_pkg::ST_ECHO: begin
            cmd.res  = ttyld_pkg::RES_ECHO;
            cmd.emit = status.out_free;
            if (status.out_free) state_in = ttyld_pkg::ST_STORE;
         end
         ttyld_pkg::ST_STORE: begin
            cmd.res  = ttyld_pkg::RES_STORE;
            cmd.emit = status.out_free;
            if (status.out_free) state_in = ttyld_pkg::ST_IDLE;
         end
         ttyld_pkg::ST_EMPTY: begin
            cmd.res  = ttyld_pkg::RES_EMPTY;
            cmd.emit = status.out_free;
            if (status.out_free) state_in = ttyld_pkg::ST_IDLE;
         end
         ttyld_pkg::ST_READ: begin
            cmd.res  = ttyld_pkg::RES_READ;
            cmd.emit = status.out_free;
            if (status.out_free) state_in = ttyld_pkg::ST_IDLE;
         end
         ttyld_pkg::ST_WRITE: begin
            cmd.res  = ttyld_pkg::RES_WRITE;
            cmd.emit = status.out_free;
            if (status.out_free) state_in = ttyld_pkg::ST_IDLE;
         end
         default: state_in = ttyld_pkg::ST_IDLE;
      endcase
   end

endmodule

@@ rtl/ttyld_dp.sv @@
module ttyld_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [ttyld_pkg::OP_W-1:0]          req_op,
   input  logic [ttyld_pkg::CHAR_W-1:0]        req_char,
   input  logic                                csr_we,
   input  logic [ttyld_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [ttyld_pkg::CHAR_W-1:0]        csr_data,
   input  ttyld_pkg::cmd_type                  cmd,
   output ttyld_pkg::status_type               status,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [ttyld_pkg::KIND_W-1:0]        rsp_kind,
   output logic [ttyld_pkg::CHAR_W-1:0]        rsp_char,
   output logic                                rsp_wake,
   output logic                                rsp_last
);

   localparam int PTR_W = ttyld_pkg::PTR_W;
   localparam int CNT_W = ttyld_pkg::CNT_W;
   localparam int CHAR_W = ttyld_pkg::CHAR_W;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(ttyld_pkg::QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(ttyld_pkg::QUEUE_DEPTH);

   logic [ttyld_pkg::FLAGS_W-1:0] mode_ff;
   logic [CHAR_W-1:0]             eol_ff;
   logic [CHAR_W-1:0]             eof_ff;
   logic [CHAR_W-1:0]             intr_ff;
   logic [CHAR_W-1:0]             bell_ff;

   logic [ttyld_pkg::OP_W-1:0] op_ff;
   logic [CHAR_W-1:0]          char_ff;
   logic [PTR_W-1:0]           head_ff, head_in;
   logic [PTR_W-1:0]           tail_ff, tail_in;
   logic [CNT_W-1:0]           count_ff, count_in;

   logic                        valid_ff, valid_in;
   logic [ttyld_pkg::KIND_W-1:0] kind_ff, kind_in;
   logic [CHAR_W-1:0]           ochar_ff, ochar_in;
   logic                        wake_ff, wake_in;
   logic                        last_ff, last_in;

   logic              push;
   logic [CHAR_W-1:0] rd_char;
   logic              is_eol, is_eof, is_intr;
   logic              rd_eol, rd_eof, rd_intr;
   logic              canon, sig;
   logic [CHAR_W-1:0] shown, ctrl_shown;

   ttyld_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (ttyld_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (tail_ff),
      .wr_data (char_ff),
      .rd_en   (cmd.pop),
      .rd_addr (head_ff),
      .rd_data (rd_char)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= ttyld_pkg::MODE_RESET;
         eol_ff  <= ttyld_pkg::EOL_RESET;
         eof_ff  <= ttyld_pkg::EOF_RESET;
         intr_ff <= ttyld_pkg::INTR_RESET;
         bell_ff <= ttyld_pkg::BELL_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            ttyld_pkg::REG_MODE: mode_ff <= csr_data[ttyld_pkg::FLAGS_W-1:0];
            ttyld_pkg::REG_EOL:  eol_ff  <= csr_data;
            ttyld_pkg::REG_EOF:  eof_ff  <= csr_data;
            ttyld_pkg::REG_INTR: intr_ff <= csr_data;
            ttyld_pkg::REG_BELL: bell_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_op;
         char_ff <= req_char;
      end
   end

   assign canon   = mode_ff[ttyld_pkg::FLAG_CANON];
   assign sig     = mode_ff[ttyld_pkg::FLAG_SIG];
   assign is_eol  = (char_ff == eol_ff);
   assign is_eof  = (char_ff == eof_ff);
   assign is_intr = (char_ff == intr_ff);
   assign rd_eol  = (rd_char == eol_ff);
   assign rd_eof  = (rd_char == eof_ff);
   assign rd_intr = (rd_char == intr_ff);

   // caret form: set bit 6, keep seven bits, show DEL as '?'
   assign ctrl_shown = (char_ff | ttyld_pkg::CHAR_CTRL) & ttyld_pkg::CHAR_DEL;
   assign shown = (ctrl_shown == ttyld_pkg::CHAR_DEL) ? ttyld_pkg::CHAR_QUEST : ctrl_shown;

   assign status.op       = op_ff;
   assign status.full     = (count_ff == CNT_FULL);
   assign status.empty    = (count_ff == '0);
   assign status.bell_en  = mode_ff[ttyld_pkg::FLAG_BELL];
   assign status.echo_en  = mode_ff[ttyld_pkg::FLAG_ECHO] ||
                            (mode_ff[ttyld_pkg::FLAG_ECHONL] && is_eol);
   assign status.caret    = !is_eol && ((char_ff < ttyld_pkg::PRINT_LO) ||
                                        (char_ff > ttyld_pkg::PRINT_HI));
   assign status.out_free = !valid_ff || rsp_ready;

   assign push = cmd.emit && (cmd.res == ttyld_pkg::RES_STORE);

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push) begin
         tail_in  = (tail_ff == PTR_LAST) ? '0 : tail_ff + PTR_W'(1);
         count_in = count_ff + CNT_W'(1);
      end
      if (cmd.pop) begin
         head_in  = (head_ff == PTR_LAST) ? '0 : head_ff + PTR_W'(1);
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_comb begin
      valid_in = valid_ff && !rsp_ready;
      kind_in  = kind_ff;
      ochar_in = ochar_ff;
      wake_in  = wake_ff;
      last_in  = last_ff;
      if (cmd.emit) begin
         valid_in = 1'b1;
         kind_in  = ttyld_pkg::KIND_TERM_OUT;
         ochar_in = char_ff;
         wake_in  = 1'b0;
         last_in  = 1'b1;
         unique case (cmd.res)
            ttyld_pkg::RES_BELL: begin
               ochar_in = bell_ff;
               last_in  = 1'b0;
            end
            ttyld_pkg::RES_DROP: kind_in = ttyld_pkg::KIND_DROPPED;
            ttyld_pkg::RES_CARET: begin
               ochar_in = ttyld_pkg::CHAR_CARET;
               last_in  = 1'b0;
            end
            ttyld_pkg::RES_ECHO: begin
               ochar_in = status.caret ? shown : char_ff;
               last_in  = 1'b0;
            end
            ttyld_pkg::RES_STORE: begin
               kind_in = ttyld_pkg::KIND_STORED;
               wake_in = (sig && is_intr) || !canon || is_eol || is_eof;
            end
            ttyld_pkg::RES_EMPTY: begin
               kind_in  = ttyld_pkg::KIND_EMPTY;
               ochar_in = '0;
            end
            ttyld_pkg::RES_READ: begin
               ochar_in = rd_char;
               if (canon && rd_eof) begin
                  kind_in  = ttyld_pkg::KIND_EOF;
                  ochar_in = '0;
               end else if (sig && rd_intr) begin
                  kind_in  = ttyld_pkg::KIND_INTR;
                  ochar_in = '0;
               end else if (!canon || rd_eol) begin
                  kind_in = ttyld_pkg::KIND_READ_END;
               end else begin
                  kind_in = ttyld_pkg::KIND_READ_DATA;
               end
            end
            ttyld_pkg::RES_WRITE: kind_in = ttyld_pkg::KIND_TERM_OUT;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      ochar_ff <= ochar_in;
      wake_ff  <= wake_in;
      last_ff  <= last_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_kind  = kind_ff;
   assign rsp_char  = ochar_ff;
   assign rsp_wake  = wake_ff;
   assign rsp_last  = last_ff;

endmodule

@@ rtl/tty_line_discipline.sv @@
// Terminal line discipline for one line. A receive transfer queues a character in a
// 64-entry receive queue (echoing it, in caret form for non-printables, when enabled);
// a read transfer pops one character and classifies it; a write transfer passes its
// character to terminal output. An item is taken only while the block is idle and
// produces one to three result transfers. Each item is accepted in the idle state, decoded in
// the dispatch state, then gives its results in turn; results leave through a single output
// register, which sets the pace at one result per cycle while the consumer is ready. Operation
// code 3 gives no result. The queue memory has no reset; the fill count guards every read.
module tty_line_discipline (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_in
   input  logic [1:0]  req_tuser,   // [1:0] operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] char_out, [8] wake, [15:9] zero
   output logic [2:0]  rsp_tuser,   // [2:0] kind
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_data
);

   ttyld_pkg::cmd_type    cmd;
   ttyld_pkg::status_type status;
   logic [7:0]            rsp_char;
   logic                  rsp_wake;

   assign csr_ready = 1'b1;

   ttyld_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   ttyld_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_op    (req_tuser),
      .req_char  (req_tdata),
      .csr_we    (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_kind  (rsp_tuser),
      .rsp_char  (rsp_char),
      .rsp_wake  (rsp_wake),
      .rsp_last  (rsp_tlast)
   );

   assign rsp_tdata = {7'd0, rsp_wake, rsp_char};

endmodule

@@ sim/testbench.sv @@
module testbench;
   import ttyld_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_LIMIT = 5000;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [CHAR_W-1:0] ch;
      logic              wake;
      logic              last;
   } tty_result_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [7:0]  csr_data = '0;

   // register mirror and receive queue of the line
   logic [FLAGS_W-1:0] mode_reg = MODE_RESET;
   logic [CHAR_W-1:0]  eol_reg = EOL_RESET;
   logic [CHAR_W-1:0]  eof_reg = EOF_RESET;
   logic [CHAR_W-1:0]  intr_reg = INTR_RESET;
   logic [CHAR_W-1:0]  bell_reg = BELL_RESET;
   logic [CHAR_W-1:0]  line_buf [QUEUE_DEPTH];
   int head_ptr = 0;
   int tail_ptr = 0;
   int fill_level = 0;

   tty_result_t due_results [$];
   tty_result_t exp_res;

   int send_idle_pct = 0;
   int rcv_idle_pct = 0;
   int hold_off_left = 0;
   int cycle_count = 0;
   int mismatch_count = 0;
   int requests_taken = 0;
   int results_checked = 0;
   int kind_hits [8] = '{default: 0};

   tty_line_discipline i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // receiver: a long hold-off wins over the random stalls
   always @(negedge clock) begin
      if (hold_off_left > 0) begin
         rsp_tready <= 1'b0;
         hold_off_left <= hold_off_left - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rcv_idle_pct);
      end
   end

   function automatic void note_failure(string msg);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("MISMATCH: %s", msg);
   endfunction

   task automatic compute_tty_results(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch);
      tty_result_t res [3];
      int n;
      logic [CHAR_W-1:0] shown;
      logic [CHAR_W-1:0] popped;
      logic wake_bit;
      n = 0;
      case (op)
         OP_RECEIVE: begin
            if (fill_level == QUEUE_DEPTH) begin
               if (mode_reg[FLAG_BELL]) begin
                  res[n] = '{KIND_TERM_OUT, bell_reg, 1'b0, 1'b0};
                  n++;
               end
               res[n] = '{KIND_DROPPED, ch, 1'b0, 1'b0};
               n++;
            end else begin
               if (mode_reg[FLAG_ECHO] || (mode_reg[FLAG_ECHONL] && ch == eol_reg)) begin
                  shown = ch;
                  if (ch != eol_reg && (ch < PRINT_LO || ch > PRINT_HI)) begin
                     res[n] = '{KIND_TERM_OUT, CHAR_CARET, 1'b0, 1'b0};
                     n++;
                     shown = (ch | CHAR_CTRL) & CHAR_DEL;
                     if (shown == CHAR_DEL)
                        shown = CHAR_QUEST;
                  end
                  res[n] = '{KIND_TERM_OUT, shown, 1'b0, 1'b0};
                  n++;
               end
               line_buf[tail_ptr] = ch;
               tail_ptr = (tail_ptr == QUEUE_DEPTH - 1) ? 0 : tail_ptr + 1;
               fill_level++;
               wake_bit = (mode_reg[FLAG_SIG] && ch == intr_reg) ||
                          !mode_reg[FLAG_CANON] || ch == eol_reg || ch == eof_reg;
               res[n] = '{KIND_STORED, ch, wake_bit, 1'b0};
               n++;
            end
         end
         OP_READ: begin
            if (fill_level == 0) begin
               res[0] = '{KIND_EMPTY, 8'h00, 1'b0, 1'b0};
            end else begin
               popped = line_buf[head_ptr];
               head_ptr = (head_ptr == QUEUE_DEPTH - 1) ? 0 : head_ptr + 1;
               fill_level--;
               if (mode_reg[FLAG_CANON] && popped == eof_reg)
                  res[0] = '{KIND_EOF, 8'h00, 1'b0, 1'b0};
               else if (mode_reg[FLAG_SIG] && popped == intr_reg)
                  res[0] = '{KIND_INTR, 8'h00, 1'b0, 1'b0};
               else if (!mode_reg[FLAG_CANON] || popped == eol_reg)
                  res[0] = '{KIND_READ_END, popped, 1'b0, 1'b0};
               else
                  res[0] = '{KIND_READ_DATA, popped, 1'b0, 1'b0};
            end
            n = 1;
         end
         OP_WRITE: begin
            res[0] = '{KIND_TERM_OUT, ch, 1'b0, 1'b0};
            n = 1;
         end
         default: n = 0;
      endcase
      for (int i = 0; i < n; i++) begin
         res[i].last = (i == n - 1);
         due_results.push_back(res[i]);
      end
   endtask

   // check results before predicting: a result never belongs to an item taken at the same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            results_checked++;
            kind_hits[rsp_tuser]++;
            if (due_results.size() == 0) begin
               note_failure($sformatf("unexpected result kind %0d data %04h last %b",
                                      rsp_tuser, rsp_tdata, rsp_tlast));
            end else begin
               exp_res = due_results.pop_front();
               if (rsp_tuser !== exp_res.kind || rsp_tdata[7:0] !== exp_res.ch ||
                   rsp_tdata[8] !== exp_res.wake || rsp_tdata[15:9] !== 7'd0 ||
                   rsp_tlast !== exp_res.last)
                  note_failure($sformatf({"result %0d: expected kind %0d char %02h wake %b ",
                                          "last %b, got kind %0d char %02h wake %b ",
                                          "pad %02h last %b"},
                     results_checked, exp_res.kind, exp_res.ch, exp_res.wake, exp_res.last,
                     rsp_tuser, rsp_tdata[7:0], rsp_tdata[8], rsp_tdata[15:9], rsp_tlast));
            end
         end
         if (req_tvalid && req_tready) begin
            requests_taken++;
            compute_tty_results(req_tuser, req_tdata);
         end
      end
   end

   task automatic send_item(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= ch;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // drop valid, let every expected result arrive, then cover items that give no result
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [7:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         REG_MODE: mode_reg = val[FLAGS_W-1:0];
         REG_EOL:  eol_reg = val;
         REG_EOF:  eof_reg = val;
         REG_INTR: intr_reg = val;
         REG_BELL: bell_reg = val;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_line_config(input logic [FLAGS_W-1:0] mode, input logic [7:0] eol,
                                  input logic [7:0] eof, input logic [7:0] intr,
                                  input logic [7:0] bell);
      wait_idle();
      write_reg(REG_MODE, {3'b000, mode});
      write_reg(REG_EOL, eol);
      write_reg(REG_EOF, eof);
      write_reg(REG_INTR, intr);
      write_reg(REG_BELL, bell);
   endtask

   function automatic logic [7:0] pick_char();
      case ($urandom_range(9))
         0: return eol_reg;
         1: return eof_reg;
         2: return intr_reg;
         3: return CHAR_DEL;
         4: return 8'($urandom_range(31));
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   function automatic logic [7:0] pick_setting();
      case ($urandom_range(3))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // reset settings: echo, signals, canonical
   task automatic test_defaults();
      logic [7:0] rx_chars [11] = '{8'h68, 8'h20, 8'h7E, 8'h00, 8'h7F, 8'h80, 8'hFF,
                                    8'h03, 8'h04, 8'h0A, 8'h1F};
      send_item(OP_WRITE, 8'h41);
      send_item(OP_WRITE, 8'hFF);
      foreach (rx_chars[i])
         send_item(OP_RECEIVE, rx_chars[i]);
      repeat (12)
         send_item(OP_READ, 8'h00);
      send_item(OP_UNUSED, 8'hA5);
   endtask

   task automatic test_mode_settings();
      logic [FLAGS_W-1:0] modes [4] = '{5'd0, 5'd31, 5'd2, 5'd4};
      logic [7:0] eols [4] = '{8'h00, 8'hFF, 8'h0A, 8'h0D};
      logic [7:0] eofs [4] = '{8'hFF, 8'h00, 8'h04, 8'h1A};
      logic [7:0] intrs [4] = '{8'h7F, 8'h20, 8'h03, 8'h00};
      logic [7:0] bells [4] = '{8'h00, 8'hFF, 8'h07, 8'h55};
      for (int m = 0; m < 4; m++) begin
         set_line_config(modes[m], eols[m], eofs[m], intrs[m], bells[m]);
         send_item(OP_RECEIVE, eol_reg);
         send_item(OP_RECEIVE, eof_reg);
         send_item(OP_RECEIVE, intr_reg);
         send_item(OP_RECEIVE, CHAR_DEL);
         send_item(OP_RECEIVE, 8'h1B);
         send_item(OP_RECEIVE, 8'($urandom_range(255)));
         send_item(OP_WRITE, 8'($urandom_range(255)));
         repeat (7)
            send_item(OP_READ, 8'($urandom_range(255)));
      end
   endtask

   task automatic test_queue_overflow();
      set_line_config(5'h1F, EOL_RESET, EOF_RESET, INTR_RESET, 8'hFF);
      repeat (QUEUE_DEPTH + 4)
         send_item(OP_RECEIVE, pick_char());
      // queue stays full; drop without the bell now
      set_line_config(5'h08, EOL_RESET, EOF_RESET, INTR_RESET, BELL_RESET);
      repeat (3)
         send_item(OP_RECEIVE, pick_char());
      repeat (8)
         send_item(OP_READ, 8'h00);
   endtask

   task automatic test_output_backpressure();
      set_line_config(5'h0D, EOL_RESET, EOF_RESET, INTR_RESET, BELL_RESET);
      send_idle_pct = 0;
      rcv_idle_pct = 0;
      @(posedge clock);
      hold_off_left = 300;
      repeat (20)
         send_item(OP_RECEIVE, 8'($urandom_range(31)));
      repeat (20)
         send_item(OP_READ, 8'h00);
   endtask

   task automatic test_random_traffic(input int s_pct, input int r_pct, input int count);
      int sent;
      int burst;
      int fill_bias;
      int roll;
      logic [OP_W-1:0] op;
      set_line_config(5'($urandom_range(31)), pick_setting(), pick_setting(), pick_setting(),
                      pick_setting());
      send_idle_pct = s_pct;
      rcv_idle_pct = r_pct;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 60);
         fill_bias = $urandom_range(1) ? 85 : 25;
         for (int k = 0; k < burst && sent < count; k++) begin
            roll = $urandom_range(99);
            if (roll < 5)
               op = OP_UNUSED;
            else if (roll < 15)
               op = OP_WRITE;
            else if (roll < 15 + fill_bias * 85 / 100)
               op = OP_RECEIVE;
            else
               op = OP_READ;
            send_item(op, (op == OP_READ || op == OP_UNUSED) ? 8'($urandom_range(255)) :
                          pick_char());
            if (op != OP_UNUSED)
               sent++;
         end
      end
   endtask

   task automatic finish_run();
      int waited;
      @(negedge clock);
      req_tvalid <= 1'b0;
      waited = 0;
      while (due_results.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (20) @(posedge clock);
      while (due_results.size() != 0) begin
         exp_res = due_results.pop_front();
         note_failure($sformatf("missing result kind %0d char %02h", exp_res.kind, exp_res.ch));
      end
      $display("covered %0d requests and %0d results in %0d cycles", requests_taken,
               results_checked, cycle_count);
      $display({"kinds: out %0d stored %0d dropped %0d data %0d end %0d ",
                "eof %0d intr %0d empty %0d"},
               kind_hits[0], kind_hits[1], kind_hits[2], kind_hits[3], kind_hits[4],
               kind_hits[5], kind_hits[6], kind_hits[7]);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("end of test: mismatches");
      end
      $finish;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_defaults();
      test_mode_settings();
      test_queue_overflow();
      test_output_backpressure();
      test_random_traffic(14, 83, 38);
      test_random_traffic(83, 14, 38);
      test_random_traffic(0, 0, 38);
      finish_run();
   end

endmodule
